FILE: sv/sfr_pkg.sv
// shared types and constants for the sync frame receiver
`timescale 1ns / 1ps

package sfr_pkg;

  // hunt and frame phases
  typedef enum logic [1:0] {
    PH_HUNT_LO = 2'd0,
    PH_HUNT_HI = 2'd1,
    PH_BODY    = 2'd2
  } phase_t;

  // configuration register indexes
  localparam logic [1:0] CFG_SYNC_WORD    = 2'd0;
  localparam logic [1:0] CFG_FRAME_LENGTH = 2'd1;

  // register reset values
  localparam logic [15:0] SYNC_WORD_RST    = 16'hABCD;
  localparam logic [6:0]  FRAME_LENGTH_RST = 7'd16;

  // frame length limits
  localparam logic [6:0] FRAME_LEN_MIN = 7'd5;
  localparam logic [6:0] FRAME_LEN_MAX = 7'd64;

  // crc-16 xmodem constants
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'h0000;

  // one result item
  typedef struct packed {
    logic [7:0] data_byte;
    logic [5:0] byte_index;
    logic       last;
    logic       frame_good;
  } result_t;

endpackage

FILE: sv/sync_frame_receiver_crc16.sv
// top level of the sync word frame receiver with crc-16 check
//
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  input   | in_valid, in_stall, in_rx_byte         | in
//  result  | out_valid, out_stall, out_data_byte,   | out
//          | out_byte_index, out_last, out_frame_good|
//  config  | cfg_wr_en, cfg_index, cfg_wdata        | in
//
// one byte is taken per cycle while in_stall is low, and is handled in the
// cycle of its transfer; any result is registered in the output or skid entry.
// a two-entry output buffer (output register plus skid) lets a byte be taken
// while a result waits; in_stall rises only once the skid entry is full.
// rst_n is synchronous: hunt restarts, registers return to 0xabcd and 16.
`timescale 1ns / 1ps

module sync_frame_receiver_crc16 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_data_byte,
  output logic [5:0]  out_byte_index,
  output logic        out_last,
  output logic        out_frame_good,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  // configuration
  logic [15:0] sync_word_r;
  logic [6:0]  frame_length_r;

  // frame state
  sfr_pkg::phase_t phase_r, phase_nxt;
  logic [5:0]  byte_counter_r, byte_counter_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  checksum_low_r, checksum_low_nxt;

  // output buffer
  logic             out_valid_r, skid_valid_r;
  sfr_pkg::result_t out_data_r, skid_data_r;

  // datapath
  logic [7:0]       sync_lo, sync_hi;
  logic [6:0]       len_eff, idx_p2;
  logic [15:0]      sync_lo_crc, crc_unit_in, crc_unit_out;
  logic [7:0]       crc_unit_byte;
  logic             res_vld;
  sfr_pkg::result_t res;
  logic             in_fire, out_fire;

  assign sync_lo  = sync_word_r[7:0];
  assign sync_hi  = sync_word_r[15:8];
  assign idx_p2   = {1'b0, byte_counter_r} + 7'd2;
  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !skid_valid_r;
  assign out_fire = out_valid_r && !out_stall;

  // clamp frame length into its legal range
  always_comb begin
    if (frame_length_r < sfr_pkg::FRAME_LEN_MIN) begin
      len_eff = sfr_pkg::FRAME_LEN_MIN;
    end else if (frame_length_r > sfr_pkg::FRAME_LEN_MAX) begin
      len_eff = sfr_pkg::FRAME_LEN_MAX;
    end else begin
      len_eff = frame_length_r;
    end
  end

  // crc over the low sync byte, then one shared byte update
  sfr_crc16_byte u_crc_sync (
    .crc_in  (sfr_pkg::CRC_INIT),
    .data_in (sync_lo),
    .crc_out (sync_lo_crc)
  );

  assign crc_unit_in   = (phase_r == sfr_pkg::PH_BODY) ? crc_r : sync_lo_crc;
  assign crc_unit_byte = (phase_r == sfr_pkg::PH_BODY) ? in_rx_byte : sync_hi;

  sfr_crc16_byte u_crc_run (
    .crc_in  (crc_unit_in),
    .data_in (crc_unit_byte),
    .crc_out (crc_unit_out)
  );

  // next phase
  always_comb begin
    case (phase_r)
      sfr_pkg::PH_HUNT_HI: begin
        if (in_rx_byte == sync_hi) begin
          phase_nxt = sfr_pkg::PH_BODY;
        end else if (in_rx_byte != sync_lo) begin
          phase_nxt = sfr_pkg::PH_HUNT_LO;
        end else begin
          phase_nxt = sfr_pkg::PH_HUNT_HI;
        end
      end
      sfr_pkg::PH_BODY: begin
        if (idx_p2 > len_eff) begin
          phase_nxt = sfr_pkg::PH_HUNT_LO;
        end else begin
          phase_nxt = sfr_pkg::PH_BODY;
        end
      end
      default: begin
        if (in_rx_byte == sync_lo) begin
          phase_nxt = sfr_pkg::PH_HUNT_HI;
        end else begin
          phase_nxt = sfr_pkg::PH_HUNT_LO;
        end
      end
    endcase
  end

  // frame state updates and result item
  always_comb begin
    byte_counter_nxt = byte_counter_r;
    crc_nxt          = crc_r;
    checksum_low_nxt = checksum_low_r;
    res_vld          = 1'b0;
    res.data_byte    = in_rx_byte;
    res.byte_index   = byte_counter_r;
    res.last         = 1'b0;
    res.frame_good   = 1'b0;
    case (phase_r)
      sfr_pkg::PH_HUNT_HI: begin
        if (in_rx_byte == sync_hi) begin
          crc_nxt          = crc_unit_out;
          byte_counter_nxt = 6'd2;
        end
      end
      sfr_pkg::PH_BODY: begin
        if (idx_p2 < len_eff) begin
          crc_nxt          = crc_unit_out;
          byte_counter_nxt = byte_counter_r + 6'd1;
          res_vld          = 1'b1;
        end else if (idx_p2 == len_eff) begin
          checksum_low_nxt = in_rx_byte;
          byte_counter_nxt = byte_counter_r + 6'd1;
        end else begin
          res_vld          = 1'b1;
          res.data_byte    = 8'h00;
          res.last         = 1'b1;
          res.frame_good   = ({in_rx_byte, checksum_low_r} == crc_r);
          byte_counter_nxt = 6'd0;
          crc_nxt          = sfr_pkg::CRC_INIT;
        end
      end
      default: begin
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_word_r    <= sfr_pkg::SYNC_WORD_RST;
      frame_length_r <= sfr_pkg::FRAME_LENGTH_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        sfr_pkg::CFG_SYNC_WORD:    sync_word_r    <= cfg_wdata;
        sfr_pkg::CFG_FRAME_LENGTH: frame_length_r <= cfg_wdata[6:0];
        default: begin
        end
      endcase
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= sfr_pkg::PH_HUNT_LO;
      byte_counter_r <= 6'd0;
      crc_r          <= sfr_pkg::CRC_INIT;
      checksum_low_r <= 8'h00;
    end else if (in_fire) begin
      phase_r        <= phase_nxt;
      byte_counter_r <= byte_counter_nxt;
      crc_r          <= crc_nxt;
      checksum_low_r <= checksum_low_nxt;
    end
  end

  // output register and skid entry valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire && res_vld) begin
      if (out_valid_r && !out_fire) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  // output buffer payload
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_data_r <= skid_data_r;
      end
    end else if (in_fire && res_vld) begin
      if (out_valid_r && !out_fire) begin
        skid_data_r <= res;
      end else begin
        out_data_r <= res;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data_byte  = out_data_r.data_byte;
  assign out_byte_index = out_data_r.byte_index;
  assign out_last       = out_data_r.last;
  assign out_frame_good = out_data_r.frame_good;

endmodule

FILE: sv/sfr_crc16_byte.sv
// byte-wide crc-16 update, polynomial 0x1021, msb first
`timescale 1ns / 1ps

module sfr_crc16_byte (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);

  logic [15:0] c;

  // eight shift steps folded into one xor network
  always_comb begin
    c = crc_in ^ {data_in, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ sfr_pkg::CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule
